FILE: rtl/core/dqap_pkg.sv
package dqap_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam logic [31:0] OCTET_MAX = 32'h0000_00FF;

  // Parse phase, one-hot
  typedef enum logic [3:0] {
    PH_EXPECT = 4'b0001,
    PH_DIGITS = 4'b0010,
    PH_REJECT = 4'b0100,
    PH_ACCEPT = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [31:0]     part_value;
    logic            overflow;
    logic [1:0]      parts_done;
    logic [2:0][7:0] octets;
    phase_t          phase;
  } parse_state_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
  } result_t;

  localparam parse_state_t ST_IDLE = '{
    part_value: 32'd0,
    overflow:   1'b0,
    parts_done: 2'd0,
    octets:     24'd0,
    phase:      PH_EXPECT
  };

  // Largest last part for the number of parts already closed
  function automatic logic [31:0] last_limit(input logic [1:0] parts_done);
    logic [31:0] lim;
    case (parts_done)
      2'd0:    lim = 32'hFFFF_FFFF;
      2'd1:    lim = 32'h00FF_FFFF;
      2'd2:    lim = 32'h0000_FFFF;
      default: lim = 32'h0000_00FF;
    endcase
    return lim;
  endfunction

endpackage

FILE: rtl/core/dotted_quad_address_parser_core.sv
// Channel  Handshake              Payload            Moves
// input    in_valid / in_ready    ch                 one character per item
// output   out_valid / out_ready  valid_res, address one result per NUL
//
// One character per cycle sustained while no NUL waits on the output register.
// The parse step is a single multiply-by-ten add and compare between the input
// register and the parse state / result registers.
// Only a NUL waits while an untaken result sits in the output register; other
// characters keep flowing. Synchronous reset clears the parse state to idle.
module dotted_quad_address_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        valid_res,
  output logic [31:0] address
);
  import dqap_pkg::*;

  logic         s1_valid;
  logic [7:0]   s1_ch;
  logic         s1_go;
  parse_state_t st;
  parse_state_t st_next;
  result_t      res;

  dqap_step u_step (
    .ch      (s1_ch),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  // A NUL needs a free output register; any other character always advances
  assign s1_go    = s1_valid && ((s1_ch != CH_NUL) || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_ch <= ch;
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else if (s1_go) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && (s1_ch == CH_NUL)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go && (s1_ch == CH_NUL)) begin
      valid_res <= res.ok;
      address   <= res.addr;
    end
  end

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> address == 32'd0)
    else $error("rejected result carries a nonzero address");

  a_expect_clear: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_EXPECT |-> (st.part_value == 32'd0) && !st.overflow)
    else $error("part value not cleared while expecting a digit");

  a_overflow_sat: assert property (@(posedge clk) disable iff (rst)
    st.overflow |-> (st.part_value == 32'hFFFF_FFFF))
    else $error("overflowed part not saturated");

  a_nul_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && (s1_ch == CH_NUL) && out_valid && !out_ready
    |=> s1_valid && (s1_ch == CH_NUL))
    else $error("blocked NUL lost from input register");

  a_nul_restart: assert property (@(posedge clk) disable iff (rst)
    s1_go && (s1_ch == CH_NUL)
    |=> out_valid && (st.phase == PH_EXPECT) && (st.parts_done == 2'd0))
    else $error("parse state not returned to idle after NUL");
`endif

endmodule

FILE: rtl/core/dqap_step.sv
module dqap_step (
  input  logic [7:0]            ch,
  input  dqap_pkg::parse_state_t st,
  output dqap_pkg::parse_state_t st_next,
  output dqap_pkg::result_t     res
);
  import dqap_pkg::*;

  logic        is_digit;
  logic        is_space;
  logic [3:0]  digit;
  logic [7:0]  ch_off;
  logic [35:0] prod;
  logic        fits;
  logic        ok;
  logic [31:0] assembled;

  // Classify the character
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign ch_off   = ch - CH_ZERO;
  assign digit    = ch_off[3:0];

  // Multiply by ten and add the digit, with carry bits kept for overflow
  assign prod = {1'b0, st.part_value, 3'b000} + {3'b000, st.part_value, 1'b0}
              + {32'd0, digit};

  assign fits = !st.overflow && (st.part_value <= last_limit(st.parts_done));
  assign ok   = (st.phase == PH_ACCEPT) || ((st.phase == PH_DIGITS) && fits);

  // Merge the closed parts above the last part
  always_comb begin
    assembled = st.part_value;
    if (st.parts_done >= 2'd1) assembled = assembled | {st.octets[0], 24'd0};
    if (st.parts_done >= 2'd2) assembled = assembled | {8'd0, st.octets[1], 16'd0};
    if (st.parts_done == 2'd3) assembled = assembled | {16'd0, st.octets[2], 8'd0};
  end

  // Advance the parse state by one character
  always_comb begin
    st_next  = st;
    res.ok   = 1'b0;
    res.addr = 32'd0;
    if (ch == CH_NUL) begin
      res.ok   = ok;
      res.addr = ok ? assembled : 32'd0;
      st_next  = ST_IDLE;
    end else begin
      case (st.phase)
        PH_EXPECT: begin
          if (is_digit) begin
            st_next.part_value = {28'd0, digit};
            st_next.overflow   = 1'b0;
            st_next.phase      = PH_DIGITS;
          end else begin
            st_next.phase = PH_REJECT;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            if (prod[35:32] != 4'd0) begin
              st_next.overflow   = 1'b1;
              st_next.part_value = 32'hFFFF_FFFF;
            end else begin
              st_next.part_value = prod[31:0];
            end
          end else if (ch == CH_DOT) begin
            if ((st.parts_done == 2'd3) || st.overflow || (st.part_value > OCTET_MAX)) begin
              st_next.phase = PH_REJECT;
            end else begin
              st_next.octets[st.parts_done] = st.part_value[7:0];
              st_next.parts_done            = st.parts_done + 2'd1;
              st_next.part_value            = 32'd0;
              st_next.overflow              = 1'b0;
              st_next.phase                 = PH_EXPECT;
            end
          end else if (is_space) begin
            st_next.phase = fits ? PH_ACCEPT : PH_REJECT;
          end else begin
            st_next.phase = PH_REJECT;
          end
        end
        default: begin
          // Decision made: drop characters until NUL
        end
      endcase
    end
  end

endmodule

FILE: test/dotted_quad_address_parser_core_test.sv
module dotted_quad_address_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dqap_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  ch = CH_NUL;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        valid_res;
  logic [31:0] address;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned chars_sent     = 0;
  int unsigned failures       = 0;

  // Addresses still owed by the block, oldest first
  result_t expected_results[$];

  // Mirror of the parse state
  phase_t      mirror_phase = PH_EXPECT;
  logic [31:0] mirror_part  = '0;
  logic        mirror_ovf   = 1'b0;
  logic [1:0]  mirror_parts = '0;
  logic [7:0]  mirror_octets [3] = '{default: '0};

  dotted_quad_address_parser_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .valid_res (valid_res),
    .address   (address)
  );

  always #6 clk = ~clk;

  // The last part has whatever bits the closed parts left over
  function automatic bit last_part_fits();
    return !mirror_ovf && mirror_part <= (32'hFFFF_FFFF >> (8 * mirror_parts));
  endfunction

  // Advance the mirror by one character; a NUL yields one expected address
  function automatic void parse_char(input logic [7:0] c);
    logic [35:0] wide;
    result_t     r;
    bit          is_digit;
    bit          is_space;
    is_digit = c >= CH_ZERO && c <= CH_NINE;
    is_space = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    if (c == CH_NUL) begin
      r.ok   = mirror_phase == PH_ACCEPT || (mirror_phase == PH_DIGITS && last_part_fits());
      r.addr = '0;
      if (r.ok) begin
        r.addr = mirror_part;
        for (int i = 0; i < mirror_parts; i++)
          r.addr |= {mirror_octets[i], 24'd0} >> (8 * i);
      end
      expected_results.push_back(r);
      mirror_phase  = PH_EXPECT;
      mirror_part   = '0;
      mirror_ovf    = 1'b0;
      mirror_parts  = '0;
      mirror_octets = '{default: '0};
    end else begin
      case (mirror_phase)
        PH_EXPECT: begin
          if (is_digit) begin
            mirror_part  = 32'(c - CH_ZERO);
            mirror_ovf   = 1'b0;
            mirror_phase = PH_DIGITS;
          end else begin
            mirror_phase = PH_REJECT;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            wide = mirror_part * 36'd10 + 36'(c - CH_ZERO);
            // Saturate instead of wrapping
            if (wide[35:32] != 4'd0) begin
              mirror_ovf  = 1'b1;
              mirror_part = '1;
            end else begin
              mirror_part = wide[31:0];
            end
          end else if (c == CH_DOT) begin
            if (mirror_parts == 2'd3 || mirror_ovf || mirror_part > OCTET_MAX) begin
              mirror_phase = PH_REJECT;
            end else begin
              mirror_octets[mirror_parts] = mirror_part[7:0];
              mirror_parts++;
              mirror_part  = '0;
              mirror_ovf   = 1'b0;
              mirror_phase = PH_EXPECT;
            end
          end else if (is_space) begin
            mirror_phase = last_part_fits() ? PH_ACCEPT : PH_REJECT;
          end else begin
            mirror_phase = PH_REJECT;
          end
        end
        default: ;
      endcase
    end
  endfunction

  // Check each result against the oldest expectation, then predict from the input item
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: valid_res %0d address %h", valid_res, address);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (valid_res !== want.ok) begin
            $error("valid_res: expected %0d, got %0d", want.ok, valid_res);
            failures++;
          end
          if (address !== want.addr) begin
            $error("address: expected %h, got %h", want.addr, address);
            failures++;
          end
        end
      end
      if (in_valid && in_ready)
        parse_char(ch);
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_ready = $urandom_range(99) >= recv_stall_pct;
  end

  // Send one item and hold it until taken
  task automatic drive_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    ch       = c;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic drive_text(input string s);
    for (int i = 0; i < s.len(); i++)
      drive_char(s[i]);
  endtask

  task automatic drive_string(input string s);
    drive_text(s);
    drive_char(CH_NUL);
  endtask

  function automatic logic [7:0] random_space();
    int unsigned w;
    w = $urandom_range(5);
    return (w == 5) ? CH_SPACE : CH_TAB + 8'(w);
  endfunction

  // Decimal text of one part, now and then with a leading zero
  function automatic string decimal_part(input longint unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(7) == 0)
      s = {"0", s};
    return s;
  endfunction

  // Well-formed shape with random content, some parts pushed past their limits
  function automatic string random_address();
    int unsigned       nparts;
    longint unsigned   lim;
    longint unsigned   v;
    string             s;
    nparts = $urandom_range(1, 4);
    s = "";
    for (int p = 0; p < nparts - 1; p++) begin
      v = ($urandom_range(15) == 0) ? 64'($urandom_range(999, 256)) : 64'($urandom_range(255));
      s = {s, decimal_part(v), "."};
    end
    lim = 64'hFFFF_FFFF >> (8 * (nparts - 1));
    case ($urandom_range(6))
      0:       v = lim;
      1:       v = lim + 1;
      2:       v = 64'($urandom_range(255));
      3:       v = 64'($urandom_range(9));
      4:       v = lim * 64'($urandom_range(40, 2));
      default: v = 64'($urandom) & lim;
    endcase
    return {s, decimal_part(v)};
  endfunction

  task automatic test_well_formed();
    drive_string("1.2.3.4");
    drive_string("0");
    drive_string("255.255.255.255");
    drive_string("0.0.0.0");
    drive_string("10.1");
    drive_string("192.168.7");
    drive_string("4294967295");
    drive_string("000255.1");
    drive_text("7.8");
    drive_char(CH_CR);
    drive_char(CH_NUL);
  endtask

  task automatic test_part_limits();
    drive_string("1.16777215");
    drive_string("1.16777216");
    drive_string("1.2.65535");
    drive_string("1.2.65536");
    drive_string("1.2.3.256");
    drive_string("256.1.2.3");
    drive_string("4294967296");
    drive_string("99999999999");
    drive_string("1.99999999999");
  endtask

  task automatic test_malformed();
    drive_string("");
    drive_string(".1");
    drive_string("1..2");
    drive_string("1.");
    drive_string("1.2.3.4.5");
    drive_string("1x2");
    drive_string("1/2");
    drive_string("1:2");
    drive_string(" 1");
    drive_string("1. ");
    drive_char(8'hFF);
    drive_char(CH_NUL);
    drive_char(8'h80);
    drive_string("1");
    drive_string("1\010");
    drive_string("1\016");
  endtask

  task automatic test_after_decision();
    drive_text("12");
    drive_char(CH_SPACE);
    drive_string("x.9..");
    drive_text("9.9");
    drive_char(CH_TAB);
    drive_char(8'hFF);
    drive_string("abc");
    drive_text("4");
    drive_char(8'd11);
    drive_string("z");
    drive_text("6");
    drive_char(8'd12);
    drive_char(CH_NUL);
    drive_text("5");
    drive_char(8'd10);
    drive_char(CH_NUL);
    drive_text("1.2.3.300");
    drive_char(CH_SPACE);
    drive_string("7");
    drive_string("x123");
  endtask

  // Mostly well-formed addresses, the rest noise and corrupted addresses
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned n_chars);
    int unsigned target;
    int unsigned len;
    int unsigned pos;
    string       s;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = chars_sent + n_chars;
    while (chars_sent < target) begin
      case ($urandom_range(9))
        7: begin
          len = $urandom_range(6);
          repeat (len) drive_char(8'($urandom_range(255, 1)));
          drive_char(CH_NUL);
        end
        8: begin
          s = random_address();
          pos = $urandom_range(s.len() - 1);
          s[pos] = 8'($urandom_range(255, 1));
          drive_string(s);
        end
        default: begin
          drive_text(random_address());
          if ($urandom_range(4) == 0) begin
            drive_char(random_space());
            len = $urandom_range(4);
            repeat (len) drive_char(8'($urandom_range(255, 1)));
          end
          drive_char(CH_NUL);
        end
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_well_formed();
    test_part_limits();
    test_malformed();
    test_after_decision();
    test_random_traffic(0, 0, 280);
    test_random_traffic(68, 0, 280);
    test_random_traffic(0, 68, 280);
    test_random_traffic(7, 7, 280);
    in_valid = 1'b0;
    // Drain outstanding addresses, then give the pipeline time to show strays
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Stop a hung run
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/dqap_pkg.sv
rtl/core/dqap_step.sv
rtl/core/dotted_quad_address_parser_core.sv
test/dotted_quad_address_parser_core_test.sv
